/* rtl/core/hd_key_path_parser_defines.svh */
// ----------------------------------------------------------------------------
// hd_key_path_parser_defines.svh
// Assertion macros used by the key path parser core (hdkp_core).
// ----------------------------------------------------------------------------
`ifndef HD_KEY_PATH_PARSER_DEFINES_SVH
`define HD_KEY_PATH_PARSER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define HDKP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hdkp: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define HDKP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hdkp: next-cycle check failed");

`endif

/* rtl/core/hdkp_pkg.sv */
// ----------------------------------------------------------------------------
// hdkp_pkg
// Character codes, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
package hdkp_pkg;

    localparam int MAX_DIGITS_DEF = 10;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_M  = 8'h4D;
    localparam logic [7:0] CH_LOW_M = 8'h6D;

    localparam logic [31:0] HARDEN_BIT = 32'h8000_0000;

    localparam logic       HARDEN_RST      = 1'b1;
    localparam logic [7:0] MAX_ENTRIES_RST = 8'd255;

    typedef enum logic {
        REG_HARDEN_ENABLE = 1'b0,
        REG_MAX_ENTRIES   = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic       harden_enable;
        logic [7:0] max_entries;
    } cfg_t;

    typedef struct packed {
        logic [31:0] index_value;
        logic        index_valid;
        logic        path_done;
        logic        path_error;
        logic [7:0]  entry_total;
    } res_t;

endpackage

/* rtl/core/hdkp_cfg.sv */
// ----------------------------------------------------------------------------
// hdkp_cfg
// Configuration register file: hardening enable and entry limit.
// ----------------------------------------------------------------------------
module hdkp_cfg
    import hdkp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    output cfg_t       cfg
);

    logic       harden_reg;
    logic [7:0] max_entries_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            harden_reg      <= HARDEN_RST;
            max_entries_reg <= MAX_ENTRIES_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_HARDEN_ENABLE: harden_reg      <= cfg_data[0];
                REG_MAX_ENTRIES:   max_entries_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign cfg.harden_enable = harden_reg;
    assign cfg.max_entries   = max_entries_reg;

endmodule

/* rtl/core/hdkp_core.sv */
// ----------------------------------------------------------------------------
// hdkp_core
// Path parser state, one-character step logic and the result register.
// ----------------------------------------------------------------------------
`include "hd_key_path_parser_defines.svh"

module hdkp_core
    import hdkp_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step_en,
    input  logic [7:0] ch,
    input  cfg_t       cfg,
    input  logic       out_ready,
    output logic       out_valid,
    output res_t       res
);

    localparam int DigitW = $clog2(MAX_DIGITS + 1);

    typedef enum logic [2:0] {
        PH_LEAD         = 3'd0,
        PH_AFTER_ROOT   = 3'd1,
        PH_AFTER_ROOT_Q = 3'd2,
        PH_SEG_START    = 3'd3,
        PH_IN_SEG       = 3'd4,
        PH_AFTER_SEG_Q  = 3'd5,
        PH_SKIP         = 3'd6
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [DigitW-1:0]   cnt_reg, cnt_next;
    logic [31:0]         acc_reg, acc_next;
    logic [7:0]          ent_reg, ent_next;

    logic                out_valid_reg;
    res_t                res_reg;

    logic                fire_c;
    logic                fail_c;
    logic                clr_c;
    logic                digit_c;
    logic                hard_c;
    res_t                res_c;

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        ent_next   = ent_reg;
        fire_c     = 1'b0;
        fail_c     = 1'b0;
        clr_c      = 1'b0;
        res_c      = '0;
        digit_c    = (ch >= CH_ZERO) && (ch <= CH_NINE);
        hard_c     = (ch == CH_QUOTE) && cfg.harden_enable;

        unique case (phase_reg)
            PH_LEAD:
            begin
                if (ch == CH_LOW_M || ch == CH_UP_M)
                    phase_next = PH_AFTER_ROOT;
                else
                    fail_c = 1'b1;
            end
            PH_AFTER_ROOT, PH_AFTER_ROOT_Q, PH_AFTER_SEG_Q:
            begin
                // the root quote is taken whatever the hardening setting
                if (phase_reg == PH_AFTER_ROOT && ch == CH_QUOTE)
                    phase_next = PH_AFTER_ROOT_Q;
                else if (ch == CH_SLASH)
                begin
                    phase_next = PH_SEG_START;
                    cnt_next   = '0;
                    acc_next   = '0;
                end
                else if (ch == CH_NUL)
                begin
                    fire_c            = 1'b1;
                    res_c.path_done   = 1'b1;
                    res_c.entry_total = ent_reg;
                    clr_c             = 1'b1;
                end
                else
                    fail_c = 1'b1;
            end
            PH_SEG_START, PH_IN_SEG:
            begin
                if (digit_c)
                begin
                    if (cnt_reg >= DigitW'(MAX_DIGITS))
                        fail_c = 1'b1;
                    else
                    begin
                        cnt_next   = cnt_reg + DigitW'(1);
                        // acc * 10 + digit, wrapping at 32 bits
                        acc_next   = (acc_reg << 3) + (acc_reg << 1) + {28'd0, ch[3:0]};
                        phase_next = PH_IN_SEG;
                    end
                end
                else if (phase_reg == PH_SEG_START)
                    fail_c = 1'b1;
                else if (!(hard_c || ch == CH_SLASH || ch == CH_NUL))
                    fail_c = 1'b1;
                else if (ent_reg == cfg.max_entries)
                    fail_c = 1'b1;
                else
                begin
                    ent_next          = ent_reg + 8'd1;
                    cnt_next          = '0;
                    acc_next          = '0;
                    fire_c            = 1'b1;
                    res_c.index_valid = 1'b1;
                    res_c.index_value = hard_c ? (acc_reg | HARDEN_BIT) : acc_reg;
                    res_c.entry_total = ent_reg + 8'd1;
                    if (ch == CH_NUL)
                    begin
                        res_c.path_done = 1'b1;
                        clr_c           = 1'b1;
                    end
                    else if (ch == CH_SLASH)
                        phase_next = PH_SEG_START;
                    else
                        phase_next = PH_AFTER_SEG_Q;
                end
            end
            default:
            begin
                // skipping the rest of a bad path; unused code behaves the same
                if (ch == CH_NUL)
                    clr_c = 1'b1;
            end
        endcase

        if (fail_c)
        begin
            fire_c            = 1'b1;
            res_c             = '0;
            res_c.path_done   = 1'b1;
            res_c.path_error  = 1'b1;
            res_c.entry_total = ent_reg;
            if (ch == CH_NUL)
                clr_c = 1'b1;
            else
                phase_next = PH_SKIP;
        end

        if (clr_c)
        begin
            phase_next = PH_LEAD;
            cnt_next   = '0;
            acc_next   = '0;
            ent_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LEAD;
            cnt_reg       <= '0;
            acc_reg       <= '0;
            ent_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step_en)
            begin
                phase_reg <= phase_next;
                cnt_reg   <= cnt_next;
                acc_reg   <= acc_next;
                ent_reg   <= ent_next;
            end
            if (step_en && fire_c)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en && fire_c)
            res_reg <= res_c;
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    `HDKP_ASSERT_IMP(a_err_is_final, out_valid_reg && res_reg.path_error,
        res_reg.path_done && !res_reg.index_valid)
    `HDKP_ASSERT_NXT(a_skip_after_err, step_en && fail_c && ch != CH_NUL,
        phase_reg == PH_SKIP)
    `HDKP_ASSERT_NXT(a_count_tracks, step_en && fire_c && res_c.index_valid && !clr_c,
        ent_reg == res_reg.entry_total)
    `HDKP_ASSERT_IMP(a_digit_bound, 1'b1, cnt_reg <= DigitW'(MAX_DIGITS))

endmodule

/* rtl/core/hd_key_path_parser.sv */
// ----------------------------------------------------------------------------
// hd_key_path_parser
// Streaming key derivation path parser, one character per word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, char_code) takes one ASCII character per
//   word; byte 0 ends the path. Output channel (out_valid/out_ready) gives a
//   word for each completed index and one final word per path (path_done),
//   with path_error set on a malformed or too long path. On error the
//   consumer drops indices already delivered for that path.
//   Configuration (cfg_we/cfg_index/cfg_data) is written while idle:
//   index 0 is harden_enable, index 1 is max_entries.
// Timing:
//   A character is parsed combinationally out of the input register once the
//   result register can take its word; the result word is registered there.
//   One word per cycle is sustained while the output is not stalled.
// Reset:
//   rst_n clears the parse state to expect a leading 'm' or 'M', empties both
//   registers and restores harden_enable = 1, max_entries = 255.
// Stall:
//   While out_ready is low and a result waits, parsing pauses and in_ready
//   drops once the input register is full; nothing is lost.
// ----------------------------------------------------------------------------
module hd_key_path_parser
    import hdkp_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_code,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] index_value,
    output logic        index_valid,
    output logic        path_done,
    output logic        path_error,
    output logic [7:0]  entry_total,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    logic       s1_valid_reg;
    logic [7:0] s1_char_reg;
    logic       step_en;
    cfg_t       cfg;
    res_t       res;

    // input word moves into the parser when the result register can take one
    assign step_en  = s1_valid_reg && (!out_valid || out_ready);
    assign in_ready = !s1_valid_reg || step_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_char_reg <= char_code;
    end

    hdkp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hdkp_core #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step_en),
        .ch        (s1_char_reg),
        .cfg       (cfg),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .res       (res)
    );

    assign index_value = res.index_value;
    assign index_valid = res.index_valid;
    assign path_done   = res.path_done;
    assign path_error  = res.path_error;
    assign entry_total = res.entry_total;

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for hd_key_path_parser. A short directed path table
// runs first, then random well-formed and broken paths under several
// harden/max-entries settings. Every output word is checked against a
// cycle-free path predictor, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    import hdkp_pkg::*;

    typedef enum logic [2:0] {
        P_LEAD,
        P_ROOT,
        P_ROOT_Q,
        P_SEG_START,
        P_IN_SEG,
        P_SEG_Q,
        P_SKIP
    } phase_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       fixed;
        logic       has_word;
        res_t       word;
    } path_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  char_code = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] index_value;
    logic        index_valid;
    logic        path_done;
    logic        path_error;
    logic [7:0]  entry_total;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [7:0]  cfg_data = 8'h00;

    // predictor state and its copy of the registers
    phase_t      ph;
    logic [3:0]  seg_digits;
    logic [31:0] seg_value;
    logic [7:0]  idx_count;
    logic        harden_en;
    logic [7:0]  max_idx;

    res_t        pending_words[$];
    res_t        head_word;
    logic [7:0]  path_buf[$];
    path_row_t   dir_path[$];
    int          word_fail = 0;
    int          sent_count = 0;

    hd_key_path_parser u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .char_code   (char_code),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .index_value (index_value),
        .index_valid (index_valid),
        .path_done   (path_done),
        .path_error  (path_error),
        .entry_total (entry_total),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void clear_path();
        ph         = P_LEAD;
        seg_digits = 4'd0;
        seg_value  = 32'h0;
        idx_count  = 8'd0;
    endfunction

    function automatic bit path_fail(input logic [7:0] ch, output res_t w);
        w = res_t'{32'h0, 1'b0, 1'b1, 1'b1, idx_count};
        if (ch == CH_NUL)
            clear_path();
        else
            ph = P_SKIP;
        return 1'b1;
    endfunction

    // Advances the path state by one character; returns 1 when a word is due.
    function automatic bit parse_char(input logic [7:0] ch, output res_t w);
        logic [31:0] v;
        logic        is_digit;
        is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
        w = '0;
        case (ph)
            P_LEAD:
            begin
                if (ch == CH_LOW_M || ch == CH_UP_M)
                begin
                    ph = P_ROOT;
                    return 1'b0;
                end
                return path_fail(ch, w);
            end
            P_ROOT, P_ROOT_Q, P_SEG_Q:
            begin
                if (ph == P_ROOT && ch == CH_QUOTE)
                begin
                    ph = P_ROOT_Q;
                    return 1'b0;
                end
                if (ch == CH_SLASH)
                begin
                    ph         = P_SEG_START;
                    seg_digits = 4'd0;
                    seg_value  = 32'h0;
                    return 1'b0;
                end
                if (ch == CH_NUL)
                begin
                    w = res_t'{32'h0, 1'b0, 1'b1, 1'b0, idx_count};
                    clear_path();
                    return 1'b1;
                end
                return path_fail(ch, w);
            end
            P_SEG_START, P_IN_SEG:
            begin
                if (is_digit)
                begin
                    if (seg_digits >= MAX_DIGITS_DEF)
                        return path_fail(ch, w);
                    seg_digits = seg_digits + 4'd1;
                    seg_value  = seg_value * 32'd10 + 32'(ch - CH_ZERO);
                    ph         = P_IN_SEG;
                    return 1'b0;
                end
                if (ph == P_SEG_START)
                    return path_fail(ch, w);
                v = seg_value;
                if (ch == CH_QUOTE && harden_en)
                    v = v | HARDEN_BIT;
                else if (ch != CH_SLASH && ch != CH_NUL)
                    return path_fail(ch, w);
                if (idx_count == max_idx)
                    return path_fail(ch, w);
                idx_count  = idx_count + 8'd1;
                seg_digits = 4'd0;
                seg_value  = 32'h0;
                w = res_t'{v, 1'b1, ch == CH_NUL, 1'b0, idx_count};
                if (ch == CH_NUL)
                    clear_path();
                else
                    ph = (ch == CH_SLASH) ? P_SEG_START : P_SEG_Q;
                return 1'b1;
            end
            default:
            begin
                if (ch == CH_NUL)
                    clear_path();
                return 1'b0;
            end
        endcase
    endfunction

    // mostly zero, some short, a few long
    function automatic int idle_len(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic path_row_t free_row(input logic [7:0] ch);
        return path_row_t'{ch, 1'b0, 1'b0, res_t'('0)};
    endfunction

    function automatic path_row_t typed_row(input logic [7:0] ch, input res_t w);
        return path_row_t'{ch, 1'b1, 1'b1, w};
    endfunction

    function automatic res_t fail_word(input logic [7:0] n);
        return res_t'{32'h0, 1'b0, 1'b1, 1'b1, n};
    endfunction

    // Random path: mostly well-formed with random content, some noise.
    function automatic void build_path();
        int         nseg;
        int         nd;
        int         r;
        int         pos;
        logic [7:0] b;
        path_buf = {};
        if ($urandom_range(0, 99) < 15)
        begin
            repeat ($urandom_range(1, 8))
            begin
                b = 8'($urandom_range(0, 255));
                path_buf.push_back(b);
            end
        end
        else
        begin
            path_buf.push_back($urandom_range(0, 1) ? CH_LOW_M : CH_UP_M);
            if ($urandom_range(0, 2) == 0)
                path_buf.push_back(CH_QUOTE);
            nseg = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
            repeat (nseg)
            begin
                path_buf.push_back(CH_SLASH);
                r = $urandom_range(0, 99);
                if (r < 4)
                    nd = 0;
                else if (r < 9)
                    nd = $urandom_range(11, 12);
                else
                    nd = $urandom_range(1, 10);
                repeat (nd)
                begin
                    b = CH_ZERO + 8'($urandom_range(0, 9));
                    path_buf.push_back(b);
                end
                if ($urandom_range(0, 99) < 35)
                    path_buf.push_back(CH_QUOTE);
            end
            if ($urandom_range(0, 99) < 8)
            begin
                pos = $urandom_range(0, path_buf.size() - 1);
                b = 8'($urandom_range(0, 255));
                path_buf[pos] = b;
            end
        end
        path_buf.push_back(CH_NUL);
    endfunction

    task automatic send_char(input logic [7:0] ch, output bit has, output res_t w);
        int gap;
        gap = idle_len(((sent_count / 150) % 4) == 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= ch;
        do @(posedge clk); while (!in_ready);
        has = parse_char(ch, w);
        sent_count++;
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_words.size() != 0);
    endtask

    task automatic write_cfg(input logic h, input logic [7:0] m);
        hold_until_drained();
        // words with no result may still be in the pipe
        repeat (8) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_HARDEN_ENABLE;
        cfg_data  <= {7'h0, h};
        @(posedge clk);
        cfg_index <= REG_MAX_ENTRIES;
        cfg_data  <= m;
        @(posedge clk);
        cfg_we    <= 1'b0;
        harden_en = h;
        max_idx   = m;
    endtask

    // output side back-pressure, with calm stretches
    initial
    begin
        int stall;
        int cyc;
        bit calm;
        stall = 0;
        cyc   = 0;
        calm  = 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc % 400 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_ready <= 1'b1;
                stall = idle_len(calm);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_words.size() == 0)
            begin
                word_fail++;
                if (word_fail <= 10)
                    $display("unexpected word: idx=%h v=%b d=%b e=%b n=%0d",
                             index_value, index_valid, path_done, path_error, entry_total);
            end
            else
            begin
                head_word = pending_words.pop_front();
                if (index_value !== head_word.index_value ||
                    index_valid !== head_word.index_valid ||
                    path_done   !== head_word.path_done   ||
                    path_error  !== head_word.path_error  ||
                    entry_total !== head_word.entry_total)
                begin
                    word_fail++;
                    if (word_fail <= 10)
                        $display("word mismatch: exp idx=%h v=%b d=%b e=%b n=%0d / got idx=%h v=%b d=%b e=%b n=%0d",
                                 head_word.index_value, head_word.index_valid,
                                 head_word.path_done, head_word.path_error,
                                 head_word.entry_total, index_value, index_valid,
                                 path_done, path_error, entry_total);
                end
            end
        end
    end

    initial
    begin
        #6_400_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        logic       ph_harden[6];
        logic [7:0] ph_max[6];
        logic [7:0] m;
        bit         has;
        bit         drained;
        res_t       w;
        int         quota;
        int         half;

        ph_harden = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        ph_max    = '{8'd255, 8'd0, 8'd1, 8'd4, 8'd0, 8'd255};
        clear_path();
        harden_en = HARDEN_RST;
        max_idx   = MAX_ENTRIES_RST;

        dir_path = '{
            typed_row(CH_NUL, fail_word(8'd0)),          // empty path
            free_row(CH_LOW_M),
            typed_row(CH_NUL, res_t'{32'h0, 1'b0, 1'b1, 1'b0, 8'd0}),  // bare root
            free_row(CH_UP_M),
            free_row(CH_QUOTE),                         // root quote
            free_row(CH_SLASH),
            free_row("2"), free_row("1"), free_row("4"), free_row("7"), free_row("4"),
            free_row("8"), free_row("3"), free_row("6"), free_row("4"), free_row("7"),
            typed_row(CH_QUOTE, res_t'{32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 8'd1}),
            free_row(CH_SLASH),
            free_row("7"),
            typed_row("a", fail_word(8'd1)),            // bad char after digits
            free_row(8'hFF),                            // skipped after error
            free_row(CH_NUL),
            free_row(CH_LOW_M),
            free_row(CH_SLASH),
            typed_row(CH_NUL, fail_word(8'd0))          // empty segment
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_path[i])
        begin
            send_char(dir_path[i].ch, has, w);
            if (dir_path[i].fixed)
            begin
                if (dir_path[i].has_word)
                    pending_words.push_back(dir_path[i].word);
            end
            else if (has)
                pending_words.push_back(w);
        end

        // setting 0 is the reset state; setting 4 gets a random small limit
        for (int p = 0; p < 6; p++)
        begin
            if (p > 0)
            begin
                m = (p == 4) ? 8'($urandom_range(2, 8)) : ph_max[p];
                write_cfg(ph_harden[p], m);
            end
            quota   = sent_count + 240;
            half    = sent_count + 120;
            drained = 1'b0;
            while (sent_count < quota)
            begin
                build_path();
                foreach (path_buf[k])
                begin
                    send_char(path_buf[k], has, w);
                    if (has)
                        pending_words.push_back(w);
                end
                if (!drained && sent_count >= half)
                begin
                    hold_until_drained();
                    drained = 1'b1;
                end
            end
        end

        hold_until_drained();
        repeat (16) @(posedge clk);
        if (word_fail == 0 && pending_words.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
